/* rtl/kv_cache_block_allocator_core_defines.svh */
// Assertion macros shared by the allocator controller and datapath files.
`ifndef KV_CACHE_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define KV_CACHE_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define KVBA_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define KVBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/kvba_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the allocator.
`default_nettype none
package kvba_pkg;

	localparam int POOL_BLOCKS = 256;
	localparam int MAX_GRANT   = 64;

	localparam int ID_W       = $clog2(POOL_BLOCKS);
	localparam int CNT_W      = $clog2(POOL_BLOCKS + 1);
	localparam int WORD_W     = 16;
	localparam int WORDS      = POOL_BLOCKS / WORD_W;
	localparam int WSEL_W     = $clog2(WORDS);
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int GRANT_W    = $clog2(MAX_GRANT + 1);

	localparam int TOK_W      = 16;
	localparam int BS_W       = 13;
	localparam int BIU_W      = 9;
	localparam int FID_W      = 9;
	localparam int STAT_W     = 3;
	localparam int SHOWN_W    = 13;
	localparam int SHOWN_MAX  = (2 ** SHOWN_W) - 1;

	localparam int DIV_STEPS  = TOK_W / 2;
	localparam int DIVCNT_W   = $clog2(DIV_STEPS);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 32;
	localparam int M_TUSER_W  = STAT_W + 1;
	localparam int M_PAD_W    = M_TDATA_W - ID_W - SHOWN_W - CNT_W;

	localparam logic [BS_W-1:0]  BS_RESET  = BS_W'(16);
	localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(256);

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_SIZE    = 1'b0,
		CFG_BLOCKS_IN_USE = 1'b1
	} cfg_reg_t;

	typedef enum logic [STAT_W-1:0] {
		RS_OK        = 3'd0,
		RS_SHORT     = 3'd1,
		RS_TOO_LARGE = 3'd2,
		RS_RANGE     = 3'd3,
		RS_ALREADY   = 3'd4
	} res_status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_DIV,
		FSM_FIN,
		FSM_DECIDE,
		FSM_SCAN,
		FSM_FREE
	} fsm_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic fin;
		logic emit_single;
		logic grant;
		logic adv;
		logic free_op;
		logic use_fid;
	} kvba_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;
		logic fail;
		logic word_nz;
		logic last_grant;
		logic out_free;
	} kvba_stat_t;

endpackage
`default_nettype wire

/* rtl/kvba_ctrl.sv */
// Controller state machine: sequences divide, decision, bitmap scan and free handling.
`default_nettype none
`include "kv_cache_block_allocator_core_defines.svh"
module kvba_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              action,
	output logic                   s_tready,
	output kvba_pkg::kvba_cmd_t    cmd,
	input  wire kvba_pkg::kvba_stat_t stat
);
	import kvba_pkg::*;

	fsm_state_t state_q;
	fsm_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = (action == ACT_FREE) ? FSM_FREE : FSM_DIV;
				end
			end
			FSM_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = FSM_FIN;
				end
			end
			FSM_FIN: begin
				cmd.fin = 1'b1;
				state_d = FSM_DECIDE;
			end
			FSM_DECIDE: begin
				if (stat.fail) begin
					if (stat.out_free) begin
						cmd.emit_single = 1'b1;
						state_d         = FSM_IDLE;
					end
				end else begin
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (!stat.word_nz) begin
					cmd.adv = 1'b1;
				end else if (stat.out_free) begin
					cmd.grant = 1'b1;
					if (stat.last_grant) begin
						state_d = FSM_IDLE;
					end
				end
			end
			FSM_FREE: begin
				cmd.use_fid = 1'b1;
				if (stat.out_free) begin
					cmd.free_op = 1'b1;
					state_d     = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	`KVBA_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_q != FSM_IDLE, "item did not start")

endmodule
`default_nettype wire

/* rtl/kvba_dp.sv */
// Datapath: configuration, divider, free bitmap, free counter and output register.
`default_nettype none
`include "kv_cache_block_allocator_core_defines.svh"
module kvba_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire kvba_pkg::kvba_cmd_t               cmd,
	output kvba_pkg::kvba_stat_t                   stat,
	input  wire logic [kvba_pkg::TOK_W-1:0]        token_count,
	input  wire logic [kvba_pkg::FID_W-1:0]        ret_id,
	input  wire logic                              cfg_valid,
	input  wire logic [kvba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [kvba_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              m_tready,
	output logic                                   m_tvalid,
	output logic [kvba_pkg::M_TDATA_W-1:0]         m_tdata,
	output logic [kvba_pkg::M_TUSER_W-1:0]         m_tuser,
	output logic                                   m_tlast
);
	import kvba_pkg::*;

	// Clamp a managed count to the pool size.
	function automatic logic [CNT_W-1:0] managed(input logic [BIU_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = (v > BIU_W'(POOL_BLOCKS)) ? CNT_W'(POOL_BLOCKS) : CNT_W'(v);
		return r;
	endfunction

	logic [BS_W-1:0]                 bst_q;
	logic [BIU_W-1:0]                biu_q;
	logic [WORDS-1:0][WORD_W-1:0]    map_q;
	logic [CNT_W-1:0]                free_total_q;
	logic [TOK_W-1:0]                quo_q;
	logic [BS_W-1:0]                 rem_q;
	logic [DIVCNT_W-1:0]             div_cnt_q;
	logic [TOK_W-1:0]                needed_q;
	logic [FID_W-1:0]                fid_q;
	logic [WSEL_W-1:0]               w_q;
	logic [GRANT_W-1:0]              granted_q;

	logic                            m_valid_q;
	res_status_t                     m_status_q;
	logic [ID_W-1:0]                 m_id_q;
	logic                            m_idv_q;
	logic [SHOWN_W-1:0]              m_count_q;
	logic [CNT_W-1:0]                m_free_q;
	logic                            m_last_q;

	logic [CNT_W-1:0]                n;
	logic [BS_W-1:0]                 bs;
	logic [BS_W:0]                   t1, t2;
	logic                            ge1, ge2;
	logic [BS_W-1:0]                 r1, r2;
	logic [TOK_W-1:0]                q1, q2;
	logic [TOK_W-1:0]                needed_d;
	logic                            is_zero, too_large, too_short;
	res_status_t                     single_status;
	logic [SHOWN_W-1:0]              shown;
	logic [WSEL_W-1:0]               rd_addr;
	logic [WORD_W-1:0]               rd_word;
	logic [BIT_W-1:0]                low_bit;
	logic [GRANT_W-1:0]              granted_inc;
	logic                            in_range;
	logic                            already;
	logic                            free_ok;
	res_status_t                     free_status;
	logic                            out_free;
	logic                            cfg_we;
	logic                            emit;

	assign n      = managed(biu_q);
	assign bs     = (bst_q == '0) ? BS_W'(1) : bst_q;
	assign cfg_we = cfg_valid;
	assign emit   = cmd.emit_single || cmd.grant || cmd.free_op;

	// Two restoring divide steps per cycle.
	always_comb begin
		t1  = {rem_q, quo_q[TOK_W-1]};
		ge1 = t1 >= {1'b0, bs};
		r1  = ge1 ? BS_W'(t1 - {1'b0, bs}) : t1[BS_W-1:0];
		q1  = {quo_q[TOK_W-2:0], ge1};
		t2  = {r1, q1[TOK_W-1]};
		ge2 = t2 >= {1'b0, bs};
		r2  = ge2 ? BS_W'(t2 - {1'b0, bs}) : t2[BS_W-1:0];
		q2  = {q1[TOK_W-2:0], ge2};
	end

	// Round the quotient up and classify the request.
	assign needed_d  = quo_q + TOK_W'(rem_q != '0);
	assign is_zero   = (needed_q == '0);
	assign too_large = (needed_q > TOK_W'(MAX_GRANT));
	assign too_short = (needed_q > TOK_W'(free_total_q));
	assign shown     = (needed_q > TOK_W'(SHOWN_MAX)) ? SHOWN_W'(SHOWN_MAX)
		: needed_q[SHOWN_W-1:0];

	always_comb begin
		if (is_zero) begin
			single_status = RS_OK;
		end else if (too_large) begin
			single_status = RS_TOO_LARGE;
		end else begin
			single_status = RS_SHORT;
		end
	end

	// Read one bitmap word and find its lowest free block.
	assign rd_addr = cmd.use_fid ? fid_q[ID_W-1:BIT_W] : w_q;
	assign rd_word = map_q[rd_addr];

	always_comb begin
		low_bit = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (rd_word[b]) begin
				low_bit = BIT_W'(b);
			end
		end
	end

	assign granted_inc = granted_q + GRANT_W'(1);

	// Check a returned block.
	assign in_range = (fid_q < FID_W'(n));
	assign already  = rd_word[fid_q[BIT_W-1:0]];
	assign free_ok  = in_range && !already;

	always_comb begin
		if (!in_range) begin
			free_status = RS_RANGE;
		end else if (already) begin
			free_status = RS_ALREADY;
		end else begin
			free_status = RS_OK;
		end
	end

	assign out_free = !m_valid_q || m_tready;

	assign stat.div_last   = (div_cnt_q == DIVCNT_W'(DIV_STEPS - 1));
	assign stat.fail       = is_zero || too_large || too_short;
	assign stat.word_nz    = (rd_word != '0);
	assign stat.last_grant = (granted_inc == needed_q[GRANT_W-1:0]);
	assign stat.out_free   = out_free;

	// Configuration, bitmap and free counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q        <= BS_RESET;
			biu_q        <= BIU_RESET;
			map_q        <= '1;
			free_total_q <= managed(BIU_RESET);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_BLOCK_SIZE: begin
					bst_q <= cfg_data[BS_W-1:0];
				end
				CFG_BLOCKS_IN_USE: begin
					biu_q        <= cfg_data[BIU_W-1:0];
					map_q        <= '1;
					free_total_q <= managed(cfg_data[BIU_W-1:0]);
				end
				default: begin
					bst_q <= bst_q;
				end
			endcase
		end else if (cmd.grant) begin
			map_q[w_q][low_bit] <= 1'b0;
			free_total_q        <= free_total_q - CNT_W'(1);
		end else if (cmd.free_op && free_ok) begin
			map_q[fid_q[ID_W-1:BIT_W]][fid_q[BIT_W-1:0]] <= 1'b1;
			free_total_q <= free_total_q + CNT_W'(1);
		end
	end

	// Divider, request and scan registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q     <= token_count;
			rem_q     <= '0;
			div_cnt_q <= '0;
			fid_q     <= ret_id;
			w_q       <= '0;
			granted_q <= '0;
		end else if (cmd.div_step) begin
			quo_q     <= q2;
			rem_q     <= r2;
			div_cnt_q <= div_cnt_q + DIVCNT_W'(1);
		end else if (cmd.adv) begin
			w_q <= w_q + WSEL_W'(1);
		end else if (cmd.grant) begin
			granted_q <= granted_inc;
		end
		if (cmd.fin) begin
			needed_q <= needed_d;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit_single) begin
			m_status_q <= single_status;
			m_id_q     <= '0;
			m_idv_q    <= 1'b0;
			m_count_q  <= shown;
			m_free_q   <= free_total_q;
			m_last_q   <= 1'b1;
		end else if (cmd.grant) begin
			m_status_q <= RS_OK;
			m_id_q     <= {w_q, low_bit};
			m_idv_q    <= 1'b1;
			m_count_q  <= shown;
			m_free_q   <= free_total_q - CNT_W'(1);
			m_last_q   <= stat.last_grant;
		end else if (cmd.free_op) begin
			m_status_q <= free_status;
			m_id_q     <= '0;
			m_idv_q    <= 1'b0;
			m_count_q  <= '0;
			m_free_q   <= free_ok ? free_total_q + CNT_W'(1) : free_total_q;
			m_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, m_free_q, m_count_q, m_id_q};
	assign m_tuser  = {m_idv_q, m_status_q};
	assign m_tlast  = m_last_q;

	`KVBA_ASSERT(a_total_in_range, 1'b1, free_total_q <= n, "free count above managed count")
	`KVBA_ASSERT(a_emit_has_room, emit, out_free, "result written over a waiting one")
	`KVBA_ASSERT(a_grant_below_need, cmd.grant, TOK_W'(granted_q) < needed_q, "granted past need")
	`KVBA_ASSERT(a_scan_in_pool, cmd.adv, w_q != WSEL_W'(WORDS - 1), "scan ran past the pool")

endmodule
`default_nettype wire

/* rtl/kv_cache_block_allocator_core.sv */
// Top level of the paged KV-cache block allocator.
`default_nettype none
// Allocates and returns cache blocks from a pool of 256, tracked by a free bitmap and a
// free counter. A free item has its single result registered from the free-handling
// state once the output register is free. A granted allocate item runs the block-count
// divider, which retires two quotient bits per cycle, then rounds up, decides and
// grants; a zero-block, oversized or unservable request answers from the decision
// state. A granted request then yields one block per cycle while results are taken and
// the scanned 16-block bitmap word holds a free block; a word with none is skipped.
// Input is taken only between items; results sit in an output register, so a new item
// may be accepted while the last result of the previous one still waits. Writing
// blocks_in_use frees the whole pool at once; the user must write configuration only
// while the block is idle, which the block itself does not enforce.
module kv_cache_block_allocator_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// [15:0] token_count, [24:16] returned block index, [31:25] zero
	input  wire logic [kvba_pkg::S_TDATA_W-1:0]     s_tdata,
	// [0] action
	input  wire logic                               s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// [7:0] granted block index, [20:8] block_count, [29:21] free_blocks, [31:30] zero
	output logic [kvba_pkg::M_TDATA_W-1:0]          m_tdata,
	// [2:0] status, [3] id_valid
	output logic [kvba_pkg::M_TUSER_W-1:0]          m_tuser,
	output logic                                    m_tlast,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [kvba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [kvba_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import kvba_pkg::*;

	kvba_cmd_t  cmd;
	kvba_stat_t stat;

	// Registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	kvba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.action   (s_tuser),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	kvba_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.token_count   (s_tdata[TOK_W-1:0]),
		.ret_id        (s_tdata[TOK_W+FID_W-1:TOK_W]),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast)
	);

endmodule
`default_nettype wire

/* test/tb_kv_cache_block_allocator_core.sv */
// Self-checking testbench for the paged KV-cache block allocator core.
`timescale 1ns / 1ps
module tb_kv_cache_block_allocator_core;
	import kvba_pkg::*;

	// One result item of the allocator
	typedef struct packed {
		res_status_t status;
		logic [7:0]  grant_id;
		logic        id_valid;
		logic [12:0] block_count;
		logic [8:0]  free_blocks;
		logic        last;
	} alloc_res_t;

	// One directed stimulus row; fixed_exp rows carry their single result typed in
	typedef struct packed {
		action_t     act;
		logic [15:0] tokens;
		logic [8:0]  fid;
		logic        fixed_exp;
		res_status_t status;
		logic [12:0] count;
		logic [8:0]  free_after;
	} dir_row_t;

	localparam int DIR_ROWS = 22;
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{ACT_ALLOC, 16'd0,     9'd0,   1'b1, RS_OK,        13'd0,    9'd256},
		'{ACT_ALLOC, 16'd65535, 9'd511, 1'b1, RS_TOO_LARGE, 13'd4096, 9'd256},
		'{ACT_ALLOC, 16'd1025,  9'd0,   1'b1, RS_TOO_LARGE, 13'd65,   9'd256},
		'{ACT_ALLOC, 16'd1024,  9'd0,   1'b0, RS_OK,        13'd0,    9'd0},
		'{ACT_FREE,  16'd0,     9'd511, 1'b1, RS_RANGE,     13'd0,    9'd192},
		'{ACT_FREE,  16'd0,     9'd256, 1'b1, RS_RANGE,     13'd0,    9'd192},
		'{ACT_FREE,  16'd0,     9'd255, 1'b1, RS_ALREADY,   13'd0,    9'd192},
		'{ACT_FREE,  16'd0,     9'd0,   1'b1, RS_OK,        13'd0,    9'd193},
		'{ACT_FREE,  16'd0,     9'd0,   1'b1, RS_ALREADY,   13'd0,    9'd193},
		'{ACT_ALLOC, 16'd1,     9'd0,   1'b0, RS_OK,        13'd0,    9'd0},
		'{ACT_ALLOC, 16'd16,    9'd0,   1'b0, RS_OK,        13'd0,    9'd0},
		'{ACT_ALLOC, 16'd17,    9'd0,   1'b0, RS_OK,        13'd0,    9'd0},
		'{ACT_ALLOC, 16'd1024,  9'd0,   1'b0, RS_OK,        13'd0,    9'd0},
		'{ACT_ALLOC, 16'd1024,  9'd0,   1'b0, RS_OK,        13'd0,    9'd0},
		'{ACT_ALLOC, 16'd1024,  9'd0,   1'b1, RS_SHORT,     13'd64,   9'd61},
		'{ACT_ALLOC, 16'd977,   9'd0,   1'b1, RS_SHORT,     13'd62,   9'd61},
		'{ACT_ALLOC, 16'd976,   9'd0,   1'b0, RS_OK,        13'd0,    9'd0},
		'{ACT_ALLOC, 16'd1,     9'd0,   1'b1, RS_SHORT,     13'd1,    9'd0},
		'{ACT_FREE,  16'd0,     9'd130, 1'b1, RS_OK,        13'd0,    9'd1},
		'{ACT_ALLOC, 16'd16,    9'd0,   1'b0, RS_OK,        13'd0,    9'd0},
		'{ACT_FREE,  16'd0,     9'd170, 1'b1, RS_OK,        13'd0,    9'd1},
		'{ACT_FREE,  16'd0,     9'd341, 1'b1, RS_RANGE,     13'd0,    9'd1}
	};

	// Register settings per random phase: block size, managed block count
	localparam int SETTINGS_N = 8;
	localparam logic [12:0] SET_BS [SETTINGS_N] = '{
		13'd1, 13'd0, 13'd8191, 13'd100, 13'd7, 13'd64, 13'd16, 13'd4096
	};
	localparam logic [12:0] SET_BIU [SETTINGS_N] = '{
		13'd256, 13'd300, 13'd40, 13'd1, 13'd0, 13'h1F40, 13'd256, 13'd511
	};
	localparam int ITEMS_PER_SETTING = 20;
	localparam int EXP_DEPTH = 128;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow of the pool and the registers
	logic [POOL_BLOCKS-1:0] shadow_free_map;
	int unsigned            shadow_free_total;
	int unsigned            cur_block_size;
	int unsigned            cur_blocks_in_use;

	alloc_res_t outcome_buf [MAX_GRANT];

	// Ring of expected results, oldest at exp_rd
	alloc_res_t exp_buf [EXP_DEPTH];
	int exp_wr;
	int exp_rd;

	bit no_idle;
	int rx_hold;
	int fail_count;
	int items_sent;
	int results_seen;
	int settings_used;

	kv_cache_block_allocator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Append one expected result to the ring
	function automatic void exp_add(alloc_res_t r);
		exp_buf[exp_wr % EXP_DEPTH] = r;
		exp_wr++;
	endfunction

	// Work out the results of one item and advance the shadow pool
	function automatic int pool_outcome(action_t act, logic [15:0] tokens, logic [8:0] fid);
		int unsigned span;
		int unsigned bsz;
		int unsigned need;
		int unsigned shown;
		int unsigned got;
		res_status_t st;
		span = (cur_blocks_in_use > POOL_BLOCKS) ? POOL_BLOCKS : cur_blocks_in_use;
		if (act == ACT_FREE) begin
			if (fid >= span) begin
				st = RS_RANGE;
			end else if (shadow_free_map[fid]) begin
				st = RS_ALREADY;
			end else begin
				shadow_free_map[fid] = 1'b1;
				shadow_free_total++;
				st = RS_OK;
			end
			outcome_buf[0] = '{status: st, grant_id: 8'd0, id_valid: 1'b0, block_count: 13'd0,
				free_blocks: 9'(shadow_free_total), last: 1'b1};
			return 1;
		end
		bsz = (cur_block_size == 0) ? 1 : cur_block_size;
		need = (tokens + bsz - 1) / bsz;
		shown = (need > SHOWN_MAX) ? SHOWN_MAX : need;
		// Zero blocks, too large and short pool all answer with one result
		if (need == 0 || need > MAX_GRANT || need > shadow_free_total) begin
			if (need == 0)
				st = RS_OK;
			else if (need > MAX_GRANT)
				st = RS_TOO_LARGE;
			else
				st = RS_SHORT;
			outcome_buf[0] = '{status: st, grant_id: 8'd0, id_valid: 1'b0,
				block_count: 13'(shown), free_blocks: 9'(shadow_free_total), last: 1'b1};
			return 1;
		end
		// Grant lowest free indexes first
		got = 0;
		for (int i = 0; i < span && got < need; i++) begin
			if (shadow_free_map[i]) begin
				shadow_free_map[i] = 1'b0;
				shadow_free_total--;
				outcome_buf[got] = '{status: RS_OK, grant_id: 8'(i), id_valid: 1'b1,
					block_count: 13'(shown), free_blocks: 9'(shadow_free_total),
					last: (got + 1 == need)};
				got++;
			end
		end
		return got;
	endfunction

	// Offer one item after a random gap, then queue its results on acceptance
	task automatic offer_item(action_t act, logic [15:0] tokens, logic [8:0] fid,
		logic fixed_exp, alloc_res_t fixed_res);
		int gap;
		int n;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {7'd0, fid, tokens};
		do @(posedge clk); while (!s_tready);
		n = pool_outcome(act, tokens, fid);
		if (fixed_exp)
			exp_add(fixed_res);
		else
			for (int i = 0; i < n; i++) exp_add(outcome_buf[i]);
		items_sent++;
	endtask

	// Drop valid and hold until every queued result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (exp_wr != exp_rd);
	endtask

	// Write both registers back to back; writing the managed count refills the pool
	task automatic set_regs(logic [12:0] bs, logic [12:0] biu);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_BLOCK_SIZE;
		cfg_data  <= bs;
		do @(posedge clk); while (!cfg_ready);
		cur_block_size = bs;
		cfg_index <= CFG_BLOCKS_IN_USE;
		cfg_data  <= biu;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_blocks_in_use = biu[8:0];
		shadow_free_map = '1;
		shadow_free_total = (cur_blocks_in_use > POOL_BLOCKS) ? POOL_BLOCKS : cur_blocks_in_use;
		settings_used++;
	endtask

	// Draw one item, mostly frees of held blocks and allocations of a few blocks
	task automatic random_item();
		int unsigned span;
		int unsigned bsz;
		int unsigned k;
		int unsigned t;
		int unsigned roll;
		int unsigned free_odds;
		int held_ids [POOL_BLOCKS];
		int held_n;
		logic [15:0] tok;
		logic [8:0]  fid;
		action_t act;
		span = (cur_blocks_in_use > POOL_BLOCKS) ? POOL_BLOCKS : cur_blocks_in_use;
		bsz = (cur_block_size == 0) ? 1 : cur_block_size;
		held_n = 0;
		for (int i = 0; i < span; i++) begin
			if (!shadow_free_map[i]) begin
				held_ids[held_n] = i;
				held_n++;
			end
		end
		tok = 16'($urandom);
		fid = 9'($urandom);
		free_odds = (shadow_free_total * 4 < span) ? 60 : 35;
		if ($urandom_range(0, 99) < free_odds) begin
			act = ACT_FREE;
			roll = $urandom_range(0, 7);
			if (roll < 5 && held_n > 0)
				fid = 9'(held_ids[$urandom_range(0, held_n - 1)]);
			else if (roll < 7 && span > 0)
				fid = 9'($urandom_range(0, span - 1));
		end else begin
			act = ACT_ALLOC;
			roll = $urandom_range(0, 9);
			// Aim at a block count; near the grant limit now and then
			if (roll != 0) begin
				k = (roll == 1) ? $urandom_range(60, 68) : $urandom_range(0, 8);
				t = (k == 0) ? 0 : (k - 1) * bsz + $urandom_range(1, bsz);
				if (t <= 16'hFFFF) tok = 16'(t);
			end
		end
		offer_item(act, tok, fid, 1'b0, '0);
	endtask

	function automatic void check_field(string fname, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			fail_count++;
		end
	endfunction

	// Stall the result side before each result; honor a long hold-off when asked
	initial begin
		int w;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			w = no_idle ? 0 : $urandom_range(0, 9);
			if (rx_hold > 0) begin
				w = rx_hold;
				rx_hold = 0;
			end
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		alloc_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (exp_wr == exp_rd) begin
				$display("%0t: unexpected result, expected none, actual status %0d index %0d",
					$time, m_tuser[2:0], m_tdata[7:0]);
				fail_count++;
			end else begin
				want = exp_buf[exp_rd % EXP_DEPTH];
				exp_rd++;
				check_field("status", want.status, m_tuser[2:0]);
				check_field("id_valid", want.id_valid, m_tuser[3]);
				check_field("grant id", want.grant_id, m_tdata[7:0]);
				check_field("block_count", want.block_count, m_tdata[20:8]);
				check_field("free_blocks", want.free_blocks, m_tdata[29:21]);
				check_field("last", want.last, m_tlast);
			end
		end
	end

	// Main sequence: reset, directed rows, then random phases per register setting
	initial begin
		alloc_res_t row_res;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BLOCK_SIZE;
		cfg_data = '0;
		no_idle = 1'b0;
		rx_hold = 0;
		fail_count = 0;
		items_sent = 0;
		results_seen = 0;
		settings_used = 1;
		exp_wr = 0;
		exp_rd = 0;
		cur_block_size = 16;
		cur_blocks_in_use = 256;
		shadow_free_map = '1;
		shadow_free_total = POOL_BLOCKS;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TAB[i]) begin
			row_res = '{status: DIR_TAB[i].status, grant_id: 8'd0, id_valid: 1'b0,
				block_count: DIR_TAB[i].count, free_blocks: DIR_TAB[i].free_after, last: 1'b1};
			offer_item(DIR_TAB[i].act, DIR_TAB[i].tokens, DIR_TAB[i].fid,
				DIR_TAB[i].fixed_exp, row_res);
		end
		drain();

		for (int p = 0; p < SETTINGS_N; p++) begin
			set_regs(SET_BS[p], SET_BIU[p]);
			// Hold results back long enough to back up the input side
			if (p == 2) rx_hold = 150;
			no_idle = (p == 3);
			for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
				random_item();
				if (p == 5 && n == ITEMS_PER_SETTING / 2) drain();
			end
			drain();
		end
		no_idle = 1'b0;

		// Leave room for any stray result
		repeat (60) @(posedge clk);
		$display("Sent %0d items under %0d register settings and checked %0d results",
			items_sent, settings_used, results_seen);
		$display("Covered full, short and oversized grants, bad and repeated frees, stalls");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, exp_wr - exp_rd);
		$display("Some tests failed");
		$finish;
	end

endmodule
